// ===== rtl/pspa_pkg.sv =====
package pspa_pkg;

  localparam int STATE_W   = 32;
  localparam int AMP_W     = 32;
  localparam int SITE_W    = 5;
  localparam int KIND_W    = 3;
  localparam int NSITES_W  = 6;
  localparam int MAX_SITES = 32;
  localparam int SITE_CAP  = (MAX_SITES < STATE_W) ? MAX_SITES : STATE_W;
  localparam int POS_W     = $clog2(STATE_W);

  localparam logic [NSITES_W-1:0] NSITES_RESET = NSITES_W'(32);
  localparam logic [NSITES_W-1:0] SITE_CAP_V   = NSITES_W'(SITE_CAP);

  localparam logic [KIND_W-1:0] KIND_IDENT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_X     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_Y     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_Z     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RAISE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_LOWER = 3'd5;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int IN_TDATA_W  = 104;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 96;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_FLIP,
    OP_YROT,
    OP_ZPH,
    OP_RAISE,
    OP_LOWER,
    OP_KILL
  } op_t;

  typedef struct packed {
    logic                first;
    logic                last;
    op_t                 op;
    logic [STATE_W-1:0]  mask;
    logic [STATE_W-1:0]  basis;
    logic [AMP_W-1:0]    amp_re;
    logic [AMP_W-1:0]    amp_im;
  } entry_t;

  typedef struct packed {
    logic nonempty;
    logic full;
  } qstat_t;

endpackage

// ===== rtl/pauli_string_apply_top.sv =====
// channel | dir | handshake           | payload
// cfg     | in  | cfg_valid/cfg_ready | cfg_data = num_sites
// in      | in  | in_tvalid/in_tready | in_tdata, in_tuser, in_tlast = last_factor
// out     | out | out_tvalid/out_tready | out_tdata
//
// One factor beat per cycle sustained unless the output stalls; the last beat is
// written into the queue, then executed into the output register, raising out_tvalid.
// Execute sets throughput: it applies one queued factor each cycle unless the output stalls.
// rst_n is synchronous: clears the queue, the working term and num_sites to 32.
// Output stall: execute holds once the output register is full and not taken;
// the two-entry queue then fills and drops in_tready.
module pauli_string_apply_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [5:0]   cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // site_index[4:0], basis_state[36:5], amp_real[68:37], amp_imag[100:69], zero pad
  input  logic [103:0] in_tdata,
  // first_factor[0], factor_kind[3:1]
  input  logic [3:0]   in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_state[31:0], result_real[63:32], result_imag[95:64]
  output logic [95:0]  out_tdata
);
  import pspa_pkg::*;

  entry_t wr_entry;
  entry_t rd_entry;
  qstat_t q_stat;
  logic   push;
  logic   pop;

  pspa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .entry     (wr_entry)
  );

  pspa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .q_stat   (q_stat)
  );

  pspa_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .entry      (rd_entry),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.nonempty |-> !pop)
    else $error("pop from empty queue");

  a_result_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(pop))
    else $error("result without executed beat");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push && q_stat.nonempty)
    else $error("push into full queue");

endmodule

// ===== rtl/pspa_front.sv =====
module pspa_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pspa_pkg::NSITES_W-1:0]       cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pspa_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic [pspa_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  logic                                in_tlast,
  input  pspa_pkg::qstat_t                    q_stat,
  output logic                                push,
  output pspa_pkg::entry_t                    entry
);
  import pspa_pkg::*;

  logic [NSITES_W-1:0] num_sites_r;
  logic [NSITES_W-1:0] num_sites_nxt;
  logic [NSITES_W-1:0] eff;
  logic [SITE_W-1:0]   site;
  logic [KIND_W-1:0]   kind;
  logic                out_of_range;
  logic [POS_W-1:0]    pos;

  assign cfg_ready = 1'b1;

  always_comb begin
    num_sites_nxt = num_sites_r;
    if (cfg_valid) begin
      num_sites_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_sites_r <= NSITES_RESET;
    end else begin
      num_sites_r <= num_sites_nxt;
    end
  end

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;

  assign site         = in_tdata[SITE_W-1:0];
  assign kind         = in_tuser[KIND_W:1];
  assign eff          = (num_sites_r > SITE_CAP_V) ? SITE_CAP_V : num_sites_r;
  assign out_of_range = {1'b0, site} >= eff;
  assign pos          = POS_W'(eff - NSITES_W'(1) - {1'b0, site});

  always_comb begin
    entry        = '0;
    entry.first  = in_tuser[0];
    entry.last   = in_tlast;
    entry.mask   = STATE_W'(1) << pos;
    entry.basis  = in_tdata[SITE_W +: STATE_W];
    entry.amp_re = in_tdata[SITE_W+STATE_W +: AMP_W];
    entry.amp_im = in_tdata[SITE_W+STATE_W+AMP_W +: AMP_W];
    entry.op     = OP_NOP;
    if (kind >= KIND_X && kind <= KIND_LOWER && out_of_range) begin
      entry.op = OP_KILL;
    end else begin
      unique case (kind)
        KIND_X:     entry.op = OP_FLIP;
        KIND_Y:     entry.op = OP_YROT;
        KIND_Z:     entry.op = OP_ZPH;
        KIND_RAISE: entry.op = OP_RAISE;
        KIND_LOWER: entry.op = OP_LOWER;
        default:    entry.op = OP_NOP;
      endcase
    end
  end

endmodule

// ===== rtl/pspa_queue.sv =====
module pspa_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pspa_pkg::entry_t  wr_entry,
  input  logic              pop,
  output pspa_pkg::entry_t  rd_entry,
  output pspa_pkg::qstat_t  q_stat
);
  import pspa_pkg::*;

  entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_entry;
    end
  end

  assign rd_entry        = mem[rd_ptr_r];
  assign q_stat.nonempty = count_r != '0;
  assign q_stat.full     = count_r == QCNT_W'(QDEPTH);

endmodule

// ===== rtl/pspa_back.sv =====
module pspa_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pspa_pkg::entry_t                   entry,
  input  pspa_pkg::qstat_t                   q_stat,
  output logic                               pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pspa_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import pspa_pkg::*;

  function automatic logic [AMP_W-1:0] sat_neg(input logic [AMP_W-1:0] v);
    logic [AMP_W-1:0] r;
    if (v == {1'b1, {(AMP_W-1){1'b0}}}) begin
      r = {1'b0, {(AMP_W-1){1'b1}}};
    end else begin
      r = '0 - v;
    end
    return r;
  endfunction

  logic [STATE_W-1:0] ws_r, ws_nxt;
  logic [1:0]         ph_r, ph_nxt;
  logic               zr_r, zr_nxt;
  logic [AMP_W-1:0]   hre_r, hre_nxt;
  logic [AMP_W-1:0]   him_r, him_nxt;
  logic               ov_r, ov_nxt;
  logic [OUT_TDATA_W-1:0] od_r, od_nxt;

  logic               bit_set;
  logic               emit;
  logic [AMP_W-1:0]   re, im;

  assign pop = q_stat.nonempty && (!ov_r || out_tready);

  always_comb begin
    ws_nxt  = ws_r;
    ph_nxt  = ph_r;
    zr_nxt  = zr_r;
    hre_nxt = hre_r;
    him_nxt = him_r;
    if (entry.first) begin
      ws_nxt  = entry.basis;
      hre_nxt = entry.amp_re;
      him_nxt = entry.amp_im;
      ph_nxt  = 2'd0;
      zr_nxt  = (entry.amp_re == '0) && (entry.amp_im == '0);
    end
    bit_set = |(ws_nxt & entry.mask);
    if (!zr_nxt) begin
      unique case (entry.op)
        OP_FLIP: ws_nxt = ws_nxt ^ entry.mask;
        OP_YROT: begin
          ph_nxt = ph_nxt + (bit_set ? 2'd3 : 2'd1);
          ws_nxt = ws_nxt ^ entry.mask;
        end
        OP_ZPH: begin
          if (bit_set) ph_nxt = ph_nxt + 2'd2;
        end
        OP_RAISE: begin
          if (bit_set) zr_nxt = 1'b1;
          else         ws_nxt = ws_nxt | entry.mask;
        end
        OP_LOWER: begin
          if (bit_set) ws_nxt = ws_nxt & ~entry.mask;
          else         zr_nxt = 1'b1;
        end
        OP_KILL: zr_nxt = 1'b1;
        default: ;
      endcase
    end
    emit = entry.last && !zr_nxt && !((hre_nxt == '0) && (him_nxt == '0));

    unique case (ph_nxt)
      2'd0: begin re = hre_nxt;          im = him_nxt;          end
      2'd1: begin re = sat_neg(him_nxt); im = hre_nxt;          end
      2'd2: begin re = sat_neg(hre_nxt); im = sat_neg(him_nxt); end
      default: begin re = him_nxt;       im = sat_neg(hre_nxt); end
    endcase

    ov_nxt = ov_r;
    od_nxt = od_r;
    if (pop && emit) begin
      ov_nxt = 1'b1;
      od_nxt = {im, re, ws_nxt};
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r  <= '0;
      ph_r  <= '0;
      zr_r  <= 1'b0;
      hre_r <= '0;
      him_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (pop) begin
        ws_r  <= ws_nxt;
        ph_r  <= ph_nxt;
        zr_r  <= zr_nxt;
        hre_r <= hre_nxt;
        him_r <= him_nxt;
      end
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

endmodule
